FILE: rtl/fbq_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helpers for the queue event engine.
package fbq_pkg;

  localparam int unsigned BUFFER_DEPTH_DEF = 256;
  localparam logic [8:0] MAX_BUFFER_RESET = 9'd16;

  localparam int unsigned TIME_W = 48;
  localparam int unsigned DRAW_W = 32;
  localparam int unsigned CNT_W  = 32;
  localparam int unsigned QLEN_W = 9;
  localparam int unsigned CFG_W  = 9;
  localparam int unsigned KIND_W = 3;

  typedef logic [TIME_W-1:0] time_val_t;
  typedef logic [DRAW_W-1:0] draw_t;
  typedef logic [CNT_W-1:0]  cnt_t;

  typedef enum logic [KIND_W-1:0] {
    EV_SEED    = 3'd0,
    EV_SERVED  = 3'd1,
    EV_QUEUED  = 3'd2,
    EV_DROPPED = 3'd3,
    EV_DEPART  = 3'd4
  } event_kind_t;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } ctrl_state_t;

  // controller to datapath
  typedef struct packed {
    logic capture;  // latch the draws of an accepted transaction
    logic commit;   // run the event and load the result register
  } dp_cmd_t;

  function automatic time_val_t sat_add_time(input time_val_t a, input time_val_t b);
    logic [TIME_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TIME_W] ? '1 : s[TIME_W-1:0];
  endfunction

  function automatic cnt_t sat_inc(input cnt_t c);
    return (&c) ? c : c + cnt_t'(1);
  endfunction

endpackage

FILE: rtl/fbq_ifs.sv
`timescale 1ns / 1ps
// Input and output channel interfaces of the queue event engine.
interface fbq_in_if;
  logic              valid;
  logic              ready;
  fbq_pkg::draw_t    new_gap;
  fbq_pkg::draw_t    new_service;

  modport source (output valid, output new_gap, output new_service, input ready);
  modport sink   (input valid, input new_gap, input new_service, output ready);
endinterface

interface fbq_out_if;
  logic                                valid;
  logic                                ready;
  logic [fbq_pkg::KIND_W-1:0]          event_kind;
  fbq_pkg::time_val_t                  event_stamp;
  logic [fbq_pkg::QLEN_W-1:0]          queue_length;
  fbq_pkg::time_val_t                  busy_total;
  fbq_pkg::cnt_t                       accepted_count;
  fbq_pkg::cnt_t                       dropped_count;

  modport source (output valid, output event_kind, output event_stamp, output queue_length,
                  output busy_total, output accepted_count, output dropped_count,
                  input ready);
  modport sink   (input valid, input event_kind, input event_stamp, input queue_length,
                  input busy_total, input accepted_count, input dropped_count,
                  output ready);
endinterface

FILE: rtl/fbq_ctrl.sv
`timescale 1ns / 1ps
// Controller: handshake sequencing and output valid for the event engine.
module fbq_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output fbq_pkg::dp_cmd_t  cmd
);

  fbq_pkg::ctrl_state_t state, state_next;
  logic out_valid_next;
  logic can_load;

  // result register is free or drains this cycle
  assign can_load = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    case (state)
      fbq_pkg::ST_IDLE: begin
        if (in_valid) state_next = fbq_pkg::ST_EXEC;
      end
      fbq_pkg::ST_EXEC: begin
        if (can_load) state_next = fbq_pkg::ST_IDLE;
      end
      default: state_next = fbq_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready    = 1'b0;
    cmd.capture = 1'b0;
    cmd.commit  = 1'b0;
    case (state)
      fbq_pkg::ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      fbq_pkg::ST_EXEC: begin
        cmd.commit = can_load;
      end
      default: ;
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (cmd.commit) out_valid_next = 1'b1;
    else if (out_ready) out_valid_next = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= fbq_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

FILE: rtl/fbq_dp.sv
`timescale 1ns / 1ps
// Datapath: event state, waiting buffer memory, statistics and result register.
module fbq_dp #(
  parameter int unsigned BUFFER_DEPTH = fbq_pkg::BUFFER_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic [fbq_pkg::CFG_W-1:0]     cfg_wr_data,
  input  fbq_pkg::draw_t                new_gap,
  input  fbq_pkg::draw_t                new_service,
  input  fbq_pkg::dp_cmd_t              cmd,
  output logic [fbq_pkg::KIND_W-1:0]    event_kind,
  output fbq_pkg::time_val_t            event_stamp,
  output logic [fbq_pkg::QLEN_W-1:0]    queue_length,
  output fbq_pkg::time_val_t            busy_total,
  output fbq_pkg::cnt_t                 accepted_count,
  output fbq_pkg::cnt_t                 dropped_count
);

  localparam int unsigned PTR_W = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
  localparam int unsigned OCC_W = $clog2(BUFFER_DEPTH + 2);
  localparam int unsigned CMP_W = (OCC_W > fbq_pkg::CFG_W) ? OCC_W : fbq_pkg::CFG_W;
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(BUFFER_DEPTH - 1);
  localparam logic [OCC_W-1:0] OCC_DEPTH = OCC_W'(BUFFER_DEPTH);
  localparam logic [OCC_W-1:0] OCC_MAX = OCC_W'(BUFFER_DEPTH + 1);

  logic [fbq_pkg::CFG_W-1:0] max_buffer;

  fbq_pkg::draw_t     gap, svc;
  fbq_pkg::time_val_t clock_now, arrival_at, departure_at, busy_acc;
  fbq_pkg::draw_t     arrival_service, departure_service;
  logic               arrival_pending, departure_pending, departure_older;
  logic [OCC_W-1:0]   occupancy;
  logic [PTR_W-1:0]   wait_head, wait_tail;
  fbq_pkg::cnt_t      accepted_acc, dropped_acc;

  fbq_pkg::draw_t     wait_store [BUFFER_DEPTH];
  fbq_pkg::draw_t     head_data;

  fbq_pkg::time_val_t clock_now_next, arrival_at_next, departure_at_next, busy_acc_next;
  fbq_pkg::draw_t     arrival_service_next, departure_service_next;
  logic               arrival_pending_next, departure_pending_next, departure_older_next;
  logic [OCC_W-1:0]   occupancy_next;
  logic [PTR_W-1:0]   wait_head_next, wait_tail_next;
  fbq_pkg::cnt_t      accepted_acc_next, dropped_acc_next;
  fbq_pkg::event_kind_t kind;
  logic               mem_we;

  logic               is_seed, is_depart, has_room;
  logic [OCC_W-1:0]   occ_m1, occ_dec;

  assign is_seed   = !arrival_pending;
  assign is_depart = departure_pending &&
                     ((departure_at < arrival_at) ||
                      ((departure_at == arrival_at) && departure_older));
  assign occ_m1    = occupancy - OCC_W'(1);
  assign occ_dec   = (occupancy != '0) ? occ_m1 : occupancy;
  assign has_room  = (CMP_W'(occ_m1) < CMP_W'(max_buffer)) && (occ_m1 < OCC_DEPTH);

  always_comb begin
    clock_now_next         = clock_now;
    arrival_at_next        = arrival_at;
    arrival_service_next   = arrival_service;
    arrival_pending_next   = arrival_pending;
    departure_at_next      = departure_at;
    departure_service_next = departure_service;
    departure_pending_next = departure_pending;
    departure_older_next   = departure_older;
    occupancy_next         = occupancy;
    wait_head_next         = wait_head;
    wait_tail_next         = wait_tail;
    busy_acc_next          = busy_acc;
    accepted_acc_next      = accepted_acc;
    dropped_acc_next       = dropped_acc;
    mem_we                 = 1'b0;
    kind                   = fbq_pkg::EV_SEED;

    if (is_seed) begin
      arrival_at_next      = fbq_pkg::sat_add_time(clock_now, fbq_pkg::TIME_W'(gap));
      arrival_service_next = svc;
      arrival_pending_next = 1'b1;
      departure_older_next = departure_pending;
    end else if (is_depart) begin
      clock_now_next = departure_at;
      busy_acc_next  = fbq_pkg::sat_add_time(busy_acc, fbq_pkg::TIME_W'(departure_service));
      occupancy_next = occ_dec;
      if (occ_dec != '0) begin
        // start the oldest waiting packet
        departure_at_next      = fbq_pkg::sat_add_time(departure_at,
                                                       fbq_pkg::TIME_W'(head_data));
        departure_service_next = head_data;
        departure_pending_next = 1'b1;
        wait_head_next         = (wait_head == PTR_LAST) ? '0 : wait_head + PTR_W'(1);
      end else begin
        departure_pending_next = 1'b0;
      end
      departure_older_next = 1'b0;
      kind                 = fbq_pkg::EV_DEPART;
    end else begin
      clock_now_next       = arrival_at;
      arrival_at_next      = fbq_pkg::sat_add_time(arrival_at, fbq_pkg::TIME_W'(gap));
      arrival_service_next = svc;
      departure_older_next = departure_pending;
      if (occupancy == '0) begin
        departure_at_next      = fbq_pkg::sat_add_time(arrival_at,
                                                       fbq_pkg::TIME_W'(arrival_service));
        departure_service_next = arrival_service;
        departure_pending_next = 1'b1;
        departure_older_next   = 1'b0;
        occupancy_next         = OCC_W'(1);
        accepted_acc_next      = fbq_pkg::sat_inc(accepted_acc);
        kind                   = fbq_pkg::EV_SERVED;
      end else if (has_room) begin
        mem_we            = 1'b1;
        wait_tail_next    = (wait_tail == PTR_LAST) ? '0 : wait_tail + PTR_W'(1);
        occupancy_next    = occupancy + OCC_W'(1);
        accepted_acc_next = fbq_pkg::sat_inc(accepted_acc);
        kind              = fbq_pkg::EV_QUEUED;
      end else begin
        dropped_acc_next = fbq_pkg::sat_inc(dropped_acc);
        kind             = fbq_pkg::EV_DROPPED;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_buffer <= fbq_pkg::MAX_BUFFER_RESET;
    end else if (cfg_wr_en) begin
      max_buffer <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      gap <= new_gap;
      svc <= new_service;
    end
  end

  // waiting buffer; head read is registered every cycle and is current by the commit cycle
  always_ff @(posedge clk) begin
    if (cmd.commit && mem_we) begin
      wait_store[wait_tail] <= arrival_service;
    end
    head_data <= wait_store[wait_head];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clock_now         <= '0;
      arrival_at        <= '0;
      arrival_service   <= '0;
      arrival_pending   <= 1'b0;
      departure_at      <= '0;
      departure_service <= '0;
      departure_pending <= 1'b0;
      departure_older   <= 1'b0;
      occupancy         <= '0;
      wait_head         <= '0;
      wait_tail         <= '0;
      busy_acc          <= '0;
      accepted_acc      <= '0;
      dropped_acc       <= '0;
    end else if (cmd.commit) begin
      clock_now         <= clock_now_next;
      arrival_at        <= arrival_at_next;
      arrival_service   <= arrival_service_next;
      arrival_pending   <= arrival_pending_next;
      departure_at      <= departure_at_next;
      departure_service <= departure_service_next;
      departure_pending <= departure_pending_next;
      departure_older   <= departure_older_next;
      occupancy         <= occupancy_next;
      wait_head         <= wait_head_next;
      wait_tail         <= wait_tail_next;
      busy_acc          <= busy_acc_next;
      accepted_acc      <= accepted_acc_next;
      dropped_acc       <= dropped_acc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      event_kind     <= kind;
      event_stamp    <= clock_now_next;
      queue_length   <= fbq_pkg::QLEN_W'(occupancy_next);
      busy_total     <= busy_acc_next;
      accepted_count <= accepted_acc_next;
      dropped_count  <= dropped_acc_next;
    end
  end

  // a departure is pending exactly when the server holds a packet
  a_dep_matches_occ: assert property (@(posedge clk) disable iff (rst)
    departure_pending == (occupancy != '0))
    else $error("departure pending flag out of step with occupancy");

  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occupancy <= OCC_MAX)
    else $error("occupancy beyond buffer depth plus server");

  a_arrival_stays: assert property (@(posedge clk) disable iff (rst)
    !$fell(arrival_pending))
    else $error("pending arrival lost");

  a_state_only_on_commit: assert property (@(posedge clk) disable iff (rst)
    !$past(cmd.commit) && !$past(rst) |-> $stable(clock_now) && $stable(occupancy))
    else $error("event state changed outside a commit");

endmodule

FILE: rtl/finite_buffer_queue_event_engine.sv
`timescale 1ns / 1ps
// Top level of the queue event engine: controller plus datapath.
// Accepted draws are captured; the event update then runs the event and loads the result register,
//   which raises the result valid. No new transaction is taken until that update is done;
//   the update waits as long as the previous result is held by the receiver.
// Reset clears all event state and counters and sets max_buffer to 16; the waiting
//   buffer memory is not cleared, and no clearing pass runs.
module finite_buffer_queue_event_engine #(
  parameter int unsigned BUFFER_DEPTH = fbq_pkg::BUFFER_DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_wr_en,
  input  logic [fbq_pkg::CFG_W-1:0]  cfg_wr_data,
  fbq_in_if.sink                     in_ch,
  fbq_out_if.source                  out_ch
);

  fbq_pkg::dp_cmd_t cmd;

  fbq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd)
  );

  fbq_dp #(
    .BUFFER_DEPTH (BUFFER_DEPTH)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .new_gap        (in_ch.new_gap),
    .new_service    (in_ch.new_service),
    .cmd            (cmd),
    .event_kind     (out_ch.event_kind),
    .event_stamp    (out_ch.event_stamp),
    .queue_length   (out_ch.queue_length),
    .busy_total     (out_ch.busy_total),
    .accepted_count (out_ch.accepted_count),
    .dropped_count  (out_ch.dropped_count)
  );

endmodule

FILE: tb/finite_buffer_queue_event_engine_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the queue event engine: random traffic, stalls, buffer limits.
module finite_buffer_queue_event_engine_tb;

  localparam int unsigned WAIT_DEPTH  = fbq_pkg::BUFFER_DEPTH_DEF;
  localparam int unsigned CYCLE_LIMIT = 300000;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned MAX_PRINTS  = 60;

  typedef struct packed {
    fbq_pkg::draw_t gap;
    fbq_pkg::draw_t svc;
  } draw_pair_t;

  typedef struct packed {
    fbq_pkg::event_kind_t       kind;
    fbq_pkg::time_val_t         at;
    logic [fbq_pkg::QLEN_W-1:0] qlen;
    fbq_pkg::time_val_t         busy;
    fbq_pkg::cnt_t              n_acc;
    fbq_pkg::cnt_t              n_drop;
  } queue_event_t;

  logic clk;
  logic rst;
  logic cfg_wr_en;
  logic [fbq_pkg::CFG_W-1:0] cfg_wr_data;

  fbq_in_if  in_bus ();
  fbq_out_if out_bus ();

  finite_buffer_queue_event_engine i_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_ch       (in_bus),
    .out_ch      (out_bus)
  );

  // engine state as predicted by the testbench
  fbq_pkg::time_val_t sim_now = '0;
  fbq_pkg::time_val_t next_arrival_at = '0;
  fbq_pkg::draw_t     next_arrival_svc = '0;
  bit                 have_arrival = 1'b0;
  fbq_pkg::time_val_t dep_at = '0;
  fbq_pkg::draw_t     dep_svc = '0;
  bit                 have_dep = 1'b0;
  bit                 dep_first = 1'b0;
  int unsigned        in_system = 0;
  fbq_pkg::draw_t     waiting_svc [WAIT_DEPTH];
  logic [7:0]         wr_ptr = '0;
  logic [7:0]         rd_ptr = '0;
  fbq_pkg::time_val_t busy_sum = '0;
  fbq_pkg::cnt_t      n_accepted = '0;
  fbq_pkg::cnt_t      n_dropped = '0;
  int unsigned        buf_limit = 32'(fbq_pkg::MAX_BUFFER_RESET);

  draw_pair_t   pending_q [$];
  queue_event_t expected_q [$];
  draw_pair_t   next_item;
  queue_event_t exp_ev;

  int unsigned errors = 0;
  int unsigned cycles = 0;
  int unsigned idle_left = 0;
  int unsigned stall_left = 0;
  int unsigned hold_left = 0;
  int unsigned kind_count [5] = '{default: 0};
  bit hold_req = 1'b0;
  bit hold_taken = 1'b0;
  bit quiet = 1'b0;

  function automatic fbq_pkg::time_val_t add_clamp(fbq_pkg::time_val_t a,
                                                   fbq_pkg::time_val_t b);
    logic [fbq_pkg::TIME_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s[fbq_pkg::TIME_W]) return '1;
    return s[fbq_pkg::TIME_W-1:0];
  endfunction

  function automatic fbq_pkg::cnt_t bump_clamp(fbq_pkg::cnt_t c);
    if (c == '1) return c;
    return c + 1;
  endfunction

  // one event step of the engine
  function automatic queue_event_t run_event(fbq_pkg::draw_t gap, fbq_pkg::draw_t svc);
    queue_event_t r;
    fbq_pkg::draw_t head_svc;
    if (!have_arrival) begin
      next_arrival_at  = add_clamp(sim_now, {16'd0, gap});
      next_arrival_svc = svc;
      have_arrival     = 1'b1;
      dep_first        = have_dep;
      r.kind           = fbq_pkg::EV_SEED;
    end else if (have_dep && (dep_at < next_arrival_at ||
                              (dep_at == next_arrival_at && dep_first))) begin
      sim_now  = dep_at;
      busy_sum = add_clamp(busy_sum, {16'd0, dep_svc});
      if (in_system > 0) in_system--;
      if (in_system > 0) begin
        head_svc = waiting_svc[rd_ptr];
        rd_ptr   = rd_ptr + 8'd1;
        dep_at   = add_clamp(sim_now, {16'd0, head_svc});
        dep_svc  = head_svc;
        have_dep = 1'b1;
      end else begin
        have_dep = 1'b0;
      end
      dep_first = 1'b0;
      r.kind    = fbq_pkg::EV_DEPART;
    end else begin
      head_svc         = next_arrival_svc;
      sim_now          = next_arrival_at;
      next_arrival_at  = add_clamp(sim_now, {16'd0, gap});
      next_arrival_svc = svc;
      dep_first        = have_dep;
      if (in_system == 0) begin
        dep_at     = add_clamp(sim_now, {16'd0, head_svc});
        dep_svc    = head_svc;
        have_dep   = 1'b1;
        dep_first  = 1'b0;
        in_system  = 1;
        n_accepted = bump_clamp(n_accepted);
        r.kind     = fbq_pkg::EV_SERVED;
      end else if (in_system - 1 < buf_limit && in_system - 1 < WAIT_DEPTH) begin
        waiting_svc[wr_ptr] = head_svc;
        wr_ptr     = wr_ptr + 8'd1;
        in_system++;
        n_accepted = bump_clamp(n_accepted);
        r.kind     = fbq_pkg::EV_QUEUED;
      end else begin
        n_dropped = bump_clamp(n_dropped);
        r.kind    = fbq_pkg::EV_DROPPED;
      end
    end
    r.at     = sim_now;
    r.qlen   = in_system[fbq_pkg::QLEN_W-1:0];
    r.busy   = busy_sum;
    r.n_acc  = n_accepted;
    r.n_drop = n_dropped;
    return r;
  endfunction

  task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
    if (errors < MAX_PRINTS)
      $display("%0t: %s mismatch: got 0x%0h, expected 0x%0h", $time, field, got, want);
    errors++;
  endtask

  // mostly small whole time units so that equal event times happen often
  function automatic fbq_pkg::draw_t pick_draw();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return fbq_pkg::draw_t'($urandom_range(0, 6)) << 16;
      5, 6:          return (fbq_pkg::draw_t'($urandom_range(0, 5)) << 16) |
                            $urandom_range(0, 16'hFFFF);
      7:             return $urandom;
      8:             return $urandom_range(0, 1) ? '1 : '0;
      default:       return $urandom >> $urandom_range(0, 31);
    endcase
  endfunction

  task automatic offer(fbq_pkg::draw_t gap, fbq_pkg::draw_t svc);
    pending_q.push_back('{gap: gap, svc: svc});
  endtask

  task automatic offer_random(int n);
    repeat (n) offer(pick_draw(), pick_draw());
  endtask

  task automatic settle();
    do @(negedge clk);
    while (pending_q.size() != 0 || in_bus.valid || expected_q.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_limit(logic [fbq_pkg::CFG_W-1:0] v);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    buf_limit = 32'(v);
    @(negedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    rst         = 1'b1;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: seed, ties both ways, zero and full-scale draws, reset limit of 16
    offer(32'h0001_0000, 32'h0002_0000);
    offer(32'h0001_0000, 32'h0003_0000);
    offer(32'h0001_0000, 32'h0001_0000);
    offer(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    offer(32'h0000_0000, 32'h0000_0000);
    offer(32'h0000_0000, 32'h0000_0001);
    offer(32'h0003_0000, 32'h8000_0000);
    offer(32'h0000_0001, 32'h0000_0000);
    offer(32'h8000_0000, 32'h0002_0000);
    offer(32'h0000_0000, 32'h0002_0000);
    offer(32'h0002_0000, 32'h0002_0000);
    offer(32'h0002_0000, 32'hFFFF_FFFF);
    offer(32'hFFFF_FFFF, 32'h0001_0000);
    offer(32'h0001_0000, 32'h0001_0000);
    offer(32'h0001_0000, 32'h5555_AAAA);
    offer(32'hAAAA_5555, 32'h0000_0000);
    offer(32'h0000_0000, 32'h0001_0000);
    offer(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    offer(32'h0001_0000, 32'h0001_0000);
    offer(32'h0000_FFFF, 32'h0001_0000);
    settle();

    set_limit(9'd0);
    offer_random(110);
    settle();

    set_limit(9'd1);
    offer_random(110);
    settle();

    // receiver holds off for a long stretch here so the engine backs up
    set_limit(9'd3);
    hold_req = 1'b1;
    offer_random(110);
    settle();

    // flood: arrivals far faster than service, fills the buffer to its depth and drops the rest
    set_limit(9'd511);
    repeat (300) offer($urandom_range(0, 32'h0000_8000),
                       $urandom_range(32'h0080_0000, 32'h0100_0000));
    settle();

    set_limit(9'd256);
    offer_random(60);
    settle();

    set_limit(9'd16);
    quiet = 1'b1;
    offer_random(100);
    settle();

    repeat (10) @(posedge clk);
    $display("covered %0d seeds, %0d served, %0d queued, %0d dropped, %0d departures",
             kind_count[fbq_pkg::EV_SEED], kind_count[fbq_pkg::EV_SERVED],
             kind_count[fbq_pkg::EV_QUEUED], kind_count[fbq_pkg::EV_DROPPED],
             kind_count[fbq_pkg::EV_DEPART]);
    $display("buffer limits 16, 0, 1, 3, 511, 256, 16 with a long output hold-off");
    if (errors == 0 && expected_q.size() == 0) begin
      $display("finite_buffer_queue_event_engine test passed");
    end else begin
      $display("finite_buffer_queue_event_engine test failed");
    end
    $finish;
  end

  // driver: presents queued draws, predicts on each accepted transaction
  always @(posedge clk) begin
    if (rst) begin
      in_bus.valid       <= 1'b0;
      in_bus.new_gap     <= '0;
      in_bus.new_service <= '0;
      idle_left          <= 0;
    end else begin
      if (in_bus.valid && in_bus.ready)
        expected_q.push_back(run_event(in_bus.new_gap, in_bus.new_service));
      if (!in_bus.valid || in_bus.ready) begin
        if (idle_left != 0) begin
          in_bus.valid <= 1'b0;
          idle_left    <= idle_left - 1;
        end else if (pending_q.size() != 0 && !quiet && $urandom_range(0, 5) == 0) begin
          in_bus.valid <= 1'b0;
          idle_left    <= $urandom_range(0, 2);
        end else if (pending_q.size() != 0) begin
          next_item          = pending_q.pop_front();
          in_bus.valid       <= 1'b1;
          in_bus.new_gap     <= next_item.gap;
          in_bus.new_service <= next_item.svc;
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off, counted here
  always @(posedge clk) begin
    if (rst) begin
      hold_left  <= 0;
      hold_taken <= 1'b0;
    end else if (hold_req && !hold_taken) begin
      hold_left  <= HOLD_CYCLES;
      hold_taken <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // monitor: checks each result transaction against the oldest prediction
  always @(posedge clk) begin
    if (rst) begin
      out_bus.ready <= 1'b0;
      stall_left    <= 0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        if (out_bus.event_kind <= fbq_pkg::EV_DEPART) kind_count[out_bus.event_kind]++;
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected result", {61'd0, out_bus.event_kind}, 64'd0);
        end else begin
          exp_ev = expected_q.pop_front();
          if (out_bus.event_kind !== exp_ev.kind)
            report_mismatch("event_kind", 64'(out_bus.event_kind), 64'(exp_ev.kind));
          if (out_bus.event_stamp !== exp_ev.at)
            report_mismatch("event_stamp", 64'(out_bus.event_stamp), 64'(exp_ev.at));
          if (out_bus.queue_length !== exp_ev.qlen)
            report_mismatch("queue_length", 64'(out_bus.queue_length), 64'(exp_ev.qlen));
          if (out_bus.busy_total !== exp_ev.busy)
            report_mismatch("busy_total", 64'(out_bus.busy_total), 64'(exp_ev.busy));
          if (out_bus.accepted_count !== exp_ev.n_acc)
            report_mismatch("accepted_count", 64'(out_bus.accepted_count),
                            64'(exp_ev.n_acc));
          if (out_bus.dropped_count !== exp_ev.n_drop)
            report_mismatch("dropped_count", 64'(out_bus.dropped_count),
                            64'(exp_ev.n_drop));
        end
      end
      if (hold_left != 0) begin
        out_bus.ready <= 1'b0;
      end else if (stall_left != 0) begin
        out_bus.ready <= 1'b0;
        stall_left    <= stall_left - 1;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_bus.ready <= 1'b0;
        stall_left    <= $urandom_range(0, 2);
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("finite_buffer_queue_event_engine test failed");
      $finish;
    end
  end

endmodule

FILE: files.f
rtl/fbq_pkg.sv
rtl/fbq_ifs.sv
rtl/fbq_ctrl.sv
rtl/fbq_dp.sv
rtl/finite_buffer_queue_event_engine.sv
tb/finite_buffer_queue_event_engine_tb.sv
